@@ src/tsmm_pkg.sv @@
package tsmm_pkg;

    localparam int MAX_VECTOR  = 64;
    localparam int MAX_ROWS    = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 23;

    localparam int VL_W  = 7;
    localparam int RC_W  = 6;
    localparam int CFG_W = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 1'd1;

    localparam int ADDR_W     = $clog2(MAX_VECTOR);
    localparam int LEN_W      = $clog2(MAX_VECTOR + 1);
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
    localparam int HIST_DEPTH = (MAX_ROWS > 1) ? MAX_ROWS - 1 : 1;
    localparam int HIST_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] col;
        logic [ADDR_W-1:0] chip_addr;
        logic [HIST_W-1:0] hist_idx;
        logic              use_hist;
        logic              acc;
        logic              first;
        logic              hist_wr;
        logic              emit;
        logic              last;
    } t_cmd;

endpackage

@@ src/tsmm_ctrl.sv @@
module tsmm_ctrl
    import tsmm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_out_free,
    output t_cmd                 o_cmd
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_ROW   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_HIST  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [VL_W-1:0]   r_vl;
    logic [RC_W-1:0]   r_rc;

    logic [LEN_W-1:0]  len;
    logic [ROWS_W-1:0] rows;
    logic [RC_W-1:0]   rc_clamp;
    logic [ADDR_W:0]   col_x;
    logic [ADDR_W:0]   row_x;
    logic              accept;

    always_comb begin
        if (r_vl == '0) begin
            len = LEN_W'(1);
        end else if (int'(r_vl) > MAX_VECTOR) begin
            len = LEN_W'(MAX_VECTOR);
        end else begin
            len = LEN_W'(r_vl);
        end
        if (r_rc == '0) begin
            rc_clamp = RC_W'(1);
        end else if (int'(r_rc) > MAX_ROWS) begin
            rc_clamp = RC_W'(MAX_ROWS);
        end else begin
            rc_clamp = r_rc;
        end
        if (int'(rc_clamp) > int'(len) + 1) begin
            rows = ROWS_W'(int'(len) + 1);
        end else begin
            rows = ROWS_W'(rc_clamp);
        end
    end

    assign o_stall = (r_state != S_LOAD);
    assign accept  = i_valid && !o_stall;
    assign col_x   = {1'b0, r_col};
    assign row_x   = (ADDR_W + 1)'(r_row);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_col   = r_col;
        n_row   = r_row;
        o_cmd   = '0;
        o_cmd.wr_addr = r_pos;
        o_cmd.col     = r_col;
        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    o_cmd.wr_en = 1'b1;
                    if (LEN_W'(r_pos) + LEN_W'(1) >= len) begin
                        n_pos   = '0;
                        n_col   = '0;
                        n_row   = '0;
                        n_state = S_ROW;
                    end else begin
                        n_pos = r_pos + ADDR_W'(1);
                    end
                end
            end
            S_ROW: begin
                o_cmd.acc   = 1'b1;
                o_cmd.first = (r_col == '0);
                if (col_x >= row_x) begin
                    o_cmd.chip_addr = ADDR_W'(col_x - row_x);
                end else begin
                    o_cmd.use_hist = 1'b1;
                    o_cmd.hist_idx = HIST_W'(row_x - col_x - (ADDR_W + 1)'(1));
                end
                if (LEN_W'(r_col) + LEN_W'(1) == len) begin
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (ROWS_W'(r_row) + ROWS_W'(1) == rows);
                    if (o_cmd.last) begin
                        n_row = '0;
                        n_state = (rows > ROWS_W'(1)) ? S_HIST : S_LOAD;
                    end else begin
                        n_row   = r_row + ROW_W'(1);
                        n_col   = '0;
                        n_state = S_ROW;
                    end
                end
            end
            S_HIST: begin
                o_cmd.hist_wr   = 1'b1;
                o_cmd.hist_idx  = HIST_W'(r_row);
                o_cmd.chip_addr = ADDR_W'(len - LEN_W'(1) - LEN_W'(r_row));
                if (ROWS_W'(r_row) + ROWS_W'(2) == rows) begin
                    n_row   = '0;
                    n_state = S_LOAD;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pos   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_vl    <= VL_W'(MAX_VECTOR);
            r_rc    <= RC_W'(MAX_ROWS);
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_col   <= n_col;
            r_row   <= n_row;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VECTOR_LENGTH: r_vl <= i_cfg_data[VL_W-1:0];
                    CFG_ROW_COUNT:     r_rc <= i_cfg_data[RC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ src/tsmm_dp.sv @@
module tsmm_dp
    import tsmm_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_im,
    input  logic                          i_chip,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic signed [SUM_BITS-1:0]    o_sum_re,
    output logic signed [SUM_BITS-1:0]    o_sum_im,
    output logic                          o_last,
    output logic                          o_out_free
);

    logic [2*SAMPLE_BITS-1:0] mem_s [MAX_VECTOR];
    logic                     mem_c [MAX_VECTOR];
    logic                     r_hist [HIST_DEPTH];

    logic [2*SAMPLE_BITS-1:0] r_s_q;
    logic                     r_c_q;
    logic                     r_h_q;
    logic                     r_use_hist;
    logic                     r_first;
    logic                     r_acc_v;
    logic                     r_hw_v;
    logic [HIST_W-1:0]        r_hw_idx;

    logic signed [SUM_BITS-1:0] r_acc_re, r_acc_im;
    logic signed [SUM_BITS-1:0] n_acc_re, n_acc_im;
    logic signed [SUM_BITS-1:0] base_re, base_im, x_re, x_im;
    logic                       sign_bit;

    logic                       r_o_valid;
    logic signed [SUM_BITS-1:0] r_o_re, r_o_im;
    logic                       r_o_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_s[i_cmd.wr_addr] <= {i_sample_re, i_sample_im};
        end
        r_s_q <= mem_s[i_cmd.col];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_c[i_cmd.wr_addr] <= i_chip;
        end
        r_c_q <= mem_c[i_cmd.chip_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= 1'b0;
            end
        end else if (r_hw_v) begin
            r_hist[r_hw_idx] <= r_c_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_q      <= r_hist[i_cmd.hist_idx];
        r_use_hist <= i_cmd.use_hist;
        r_first    <= i_cmd.first;
        r_hw_idx   <= i_cmd.hist_idx;
        if (!i_rst_n) begin
            r_acc_v <= 1'b0;
            r_hw_v  <= 1'b0;
        end else begin
            r_acc_v <= i_cmd.acc;
            r_hw_v  <= i_cmd.hist_wr;
        end
    end

    always_comb begin
        sign_bit = r_use_hist ? r_h_q : r_c_q;
        x_re     = SUM_BITS'($signed(r_s_q[2*SAMPLE_BITS-1:SAMPLE_BITS]));
        x_im     = SUM_BITS'($signed(r_s_q[SAMPLE_BITS-1:0]));
        base_re  = r_first ? '0 : r_acc_re;
        base_im  = r_first ? '0 : r_acc_im;
        n_acc_re = sign_bit ? base_re + x_re : base_re - x_re;
        n_acc_im = sign_bit ? base_im + x_im : base_im - x_im;
    end

    always_ff @(posedge i_clk) begin
        if (r_acc_v) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
        end
    end

    assign o_out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_re   <= r_acc_re;
            r_o_im   <= r_acc_im;
            r_o_last <= i_cmd.last;
        end
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_sum_re = r_o_re;
    assign o_sum_im = r_o_im;
    assign o_last   = r_o_last;

endmodule

@@ src/toeplitz_sign_matrix_multiply_unit.sv @@
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_sample_re, i_sample_im, i_chip
// result    out        o_valid / i_stall  o_sum_re, o_sum_im, o_last
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// Samples are taken one per cycle until the vector of L samples is complete.
// Each of the R rows then walks the sample memory at one column a cycle with
// one complex accumulator; the row sum is emitted once the output is free.
// A chip history update of R - 1 entries follows, then the next vector loads.
// Reset is synchronous and active low; it clears the chip history to subtract.
// A stalled output holds the finished row while the next row is computed.
module toeplitz_sign_matrix_multiply_unit
    import tsmm_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_im,
    input  logic                          i_chip,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SUM_BITS-1:0]    o_sum_re,
    output logic signed [SUM_BITS-1:0]    o_sum_im,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    t_cmd cmd;
    logic out_free;

    tsmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_free  (out_free),
        .o_cmd       (cmd)
    );

    tsmm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .i_chip      (i_chip),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_sum_re    (o_sum_re),
        .o_sum_im    (o_sum_im),
        .o_last      (o_last),
        .o_out_free  (out_free)
    );

endmodule
